FILE: sv/tgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr_pkg: shared types and constants of the text console glyph renderer
// Item modes, control characters, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package tgr_pkg;

    // Fixed glyph cell width in pixels
    localparam int FONT_WIDTH = 8;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int CODE_W   = 8;
    localparam int GROW_W   = 4;
    localparam int BITS_W   = 8;
    localparam int SETPOS_W = 10;
    localparam int OFF_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_CHAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FONT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET  = 2'd2;

    // Control characters
    localparam logic [CODE_W-1:0] CH_BS  = 8'h08;
    localparam logic [CODE_W-1:0] CH_TAB = 8'h09;
    localparam logic [CODE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CODE_W-1:0] CH_CR  = 8'h0D;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COLS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PANEL_ROWS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LEN    = 3'd5;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_BASE = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

endpackage

FILE: sv/tgr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgr interfaces: valid/ready channels of the glyph renderer
// tgr_char_if carries console items, tgr_draw_if carries glyph row draws.
// ----------------------------------------------------------------------------
interface tgr_char_if;
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [7:0]        char_code;
    logic [3:0]        glyph_row;
    logic [7:0]        font_bits;
    logic signed [9:0] set_row;
    logic signed [9:0] set_col;

    modport source (output valid, mode, char_code, glyph_row, font_bits, set_row, set_col,
                    input ready);
    modport sink   (input valid, mode, char_code, glyph_row, font_bits, set_row, set_col,
                    output ready);
endinterface

interface tgr_draw_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_offset;
    logic [7:0]  row_mask;
    logic        last;

    modport source (output valid, pixel_offset, row_mask, last, input ready);
    modport sink   (input valid, pixel_offset, row_mask, last, output ready);
endinterface

FILE: sv/text_console_glyph_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer: text cursor and glyph row draw generator
// Keeps a cursor, loads a font store and turns printable characters into
// one framebuffer draw per glyph row (offset and 8-bit mask).
// ----------------------------------------------------------------------------
//  channel  | dir | transaction
//  chars    | in  | mode, char_code, glyph_row, font_bits, set_row, set_col
//  draws    | out | pixel_offset, row_mask, last (FONT_HEIGHT per printable char)
//  cfg_*    | in  | register write, one per cycle, no back-pressure
//
//  Cursor moves, font writes and cursor sets are applied as the item is taken.
//  A printable character runs one multiply, one base add, then one font
//  read per row from the font memory.
//  Reset clears cursor and pipeline, registers go to defaults; font memory is kept.
//  A stall on draws holds the row pipeline; chars is taken only when idle.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer #(
    parameter int FONT_HEIGHT = 16,
    parameter int GLYPH_COUNT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tgr_char_if.sink                        chars,
    tgr_draw_if.source                      draws,
    input  logic                            cfg_we,
    input  logic [tgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tgr_pkg::*;

    localparam int DEPTH  = GLYPH_COUNT * FONT_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(FONT_HEIGHT);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(FONT_HEIGHT - 1);

    // Configuration registers
    logic        enable_reg;
    logic        orient_reg;
    logic [7:0]  max_cols_reg;
    logic [7:0]  max_rows_reg;
    logic [11:0] panel_rows_reg;
    logic [11:0] line_len_reg;

    // Cursor and sequencer
    state_t      state_reg, state_next;
    logic [7:0]  row_reg, row_next;
    logic [7:0]  col_reg, col_next;
    logic [ROW_W-1:0] rcnt_reg;

    // Item operands
    logic [OFF_W-1:0]  mul_a_reg;
    logic [OFF_W-1:0]  add_reg;
    logic [OFF_W-1:0]  step_reg;
    logic [OFF_W-1:0]  prod_reg;
    logic [OFF_W-1:0]  acc_reg;
    logic [ADDR_W-1:0] gbase_reg;
    logic              gok_reg;

    // Row pipeline: font read stage and output stage
    logic              pend_valid_reg;
    logic [OFF_W-1:0]  pend_off_reg;
    logic              pend_last_reg;
    logic              pend_ok_reg;
    logic [7:0]        font_q_reg;
    logic              out_valid_reg;
    logic [OFF_W-1:0]  out_off_reg;
    logic [7:0]        out_mask_reg;
    logic              out_last_reg;

    logic [7:0] font_mem [DEPTH];

    logic              accept;
    logic              out_load;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] code_base;
    logic              code_ok;
    logic              grow_ok;
    logic              start_draw;
    logic [10:0]       cur_x;
    logic [11:0]       cur_y0;
    logic [7:0]        line_row;
    logic [8:0]        col_inc;
    logic [8:0]        col_tab;

    // Clamp a signed 10-bit request to 0..hi
    function automatic logic [7:0] clamp_pos(input logic [9:0] v, input logic [7:0] hi);
        logic [7:0] r;
        if (v[9] || (v == 10'd0))
            r = 8'd0;
        else if (v > {2'b00, hi})
            r = hi;
        else
            r = v[7:0];
        return r;
    endfunction

    assign accept   = chars.valid && chars.ready;
    assign out_load = pend_valid_reg && (!out_valid_reg || draws.ready);
    assign rd_en    = (state_reg == ST_EMIT) && (!pend_valid_reg || out_load);

    // Font addressing
    assign code_base = ADDR_W'(13'(chars.char_code) * 13'(FONT_HEIGHT));
    assign code_ok   = {1'b0, chars.char_code} < 9'(GLYPH_COUNT);
    assign grow_ok   = {1'b0, chars.glyph_row} < 5'(FONT_HEIGHT);
    assign wr_en     = accept && (chars.mode == MODE_FONT) && code_ok && grow_ok;
    assign wr_addr   = code_base + ADDR_W'(chars.glyph_row);
    assign rd_addr   = gbase_reg + ADDR_W'(rcnt_reg);

    // Cursor geometry
    assign cur_x    = {col_reg, 3'b000};
    assign cur_y0   = 12'(row_reg) * 12'(FONT_HEIGHT);
    assign line_row = ({1'b0, row_reg} + 9'd1 >= {1'b0, max_rows_reg}) ? 8'd0
                                                                         : row_reg + 8'd1;
    assign col_inc  = {1'b0, col_reg} + 9'd1;
    assign col_tab  = ({1'b0, col_reg} + 9'd8) & ~9'd7;

    // Cursor update and item decode
    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        start_draw = 1'b0;
        if (accept)
        begin
            case (chars.mode)
                MODE_SET:
                begin
                    row_next = clamp_pos(chars.set_row, max_rows_reg);
                    col_next = clamp_pos(chars.set_col, max_cols_reg);
                end
                MODE_CHAR:
                begin
                    if (enable_reg)
                    begin
                        case (chars.char_code)
                            CH_CR:
                                col_next = 8'd0;
                            CH_LF:
                            begin
                                row_next = line_row;
                                col_next = 8'd0;
                            end
                            CH_TAB:
                            begin
                                if (col_tab >= {1'b0, max_cols_reg})
                                begin
                                    row_next = line_row;
                                    col_next = 8'd0;
                                end
                                else
                                    col_next = col_tab[7:0];
                            end
                            CH_BS:
                            begin
                                if (col_reg == 8'd0)
                                begin
                                    col_next = max_cols_reg - 8'd1;
                                    if (row_reg != 8'd0)
                                        row_next = row_reg - 8'd1;
                                end
                                else
                                    col_next = col_reg - 8'd1;
                            end
                            default:
                            begin
                                start_draw = 1'b1;
                                if (col_inc >= {1'b0, max_cols_reg})
                                begin
                                    row_next = line_row;
                                    col_next = 8'd0;
                                end
                                else
                                    col_next = col_inc[7:0];
                            end
                        endcase
                    end
                end
                default:
                    ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start_draw)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_BASE;
            ST_BASE:
                state_next = ST_EMIT;
            ST_EMIT:
                if (rd_en && (rcnt_reg == LAST_ROW))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            row_reg        <= 8'd0;
            col_reg        <= 8'd0;
            rcnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            enable_reg     <= 1'b0;
            orient_reg     <= 1'b0;
            max_cols_reg   <= 8'd80;
            max_rows_reg   <= 8'd30;
            panel_rows_reg <= 12'd480;
            line_len_reg   <= 12'd640;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;

            if (state_reg == ST_BASE)
                rcnt_reg <= '0;
            else if (rd_en)
                rcnt_reg <= rcnt_reg + ROW_W'(1);

            if (rd_en)
                pend_valid_reg <= 1'b1;
            else if (out_load)
                pend_valid_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (draws.ready)
                out_valid_reg <= 1'b0;

            // Register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE:      enable_reg     <= cfg_data[0];
                    REG_ORIENTATION: orient_reg     <= cfg_data[0];
                    REG_MAX_COLS:    max_cols_reg   <= cfg_data[7:0];
                    REG_MAX_ROWS:    max_rows_reg   <= cfg_data[7:0];
                    REG_PANEL_ROWS:  panel_rows_reg <= cfg_data;
                    REG_LINE_LEN:    line_len_reg   <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // Offset datapath: one multiply per character, then one shared adder per row
    always_ff @(posedge clk)
    begin
        if (start_draw)
        begin
            gbase_reg <= code_base;
            gok_reg   <= code_ok;
            if (orient_reg)
            begin
                mul_a_reg <= OFF_W'(cur_y0);
                add_reg   <= OFF_W'(cur_x);
                step_reg  <= OFF_W'(line_len_reg);
            end
            else
            begin
                mul_a_reg <= OFF_W'(panel_rows_reg) - OFF_W'(1) - OFF_W'(cur_x);
                add_reg   <= OFF_W'(cur_y0);
                step_reg  <= OFF_W'(1);
            end
        end
        if (state_reg == ST_MUL)
            prod_reg <= OFF_W'(mul_a_reg * OFF_W'(line_len_reg));
        if (state_reg == ST_BASE)
            acc_reg <= prod_reg + add_reg;
        else if (rd_en)
            acc_reg <= acc_reg + step_reg;

        if (rd_en)
        begin
            pend_off_reg  <= acc_reg;
            pend_last_reg <= (rcnt_reg == LAST_ROW);
            pend_ok_reg   <= gok_reg;
        end
        if (out_load)
        begin
            out_off_reg  <= pend_off_reg;
            out_mask_reg <= pend_ok_reg ? font_q_reg : 8'd0;
            out_last_reg <= pend_last_reg;
        end
    end

    // Font memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            font_mem[wr_addr] <= chars.font_bits;
        if (rd_en)
            font_q_reg <= font_mem[rd_addr];
    end

    assign chars.ready        = (state_reg == ST_IDLE);
    assign draws.valid        = out_valid_reg;
    assign draws.pixel_offset = out_off_reg;
    assign draws.row_mask     = out_mask_reg;
    assign draws.last         = out_last_reg;

    // Checks
    a_rd_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (!pend_valid_reg || out_load))
        else $error("font read issued into a full row stage");

    a_mul_base: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_BASE))
        else $error("multiply not followed by base add");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && (rcnt_reg == LAST_ROW)) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not finish after final row");

    a_rcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (rcnt_reg <= LAST_ROW))
        else $error("glyph row counter out of range");

endmodule

FILE: test/tb_text_console_glyph_renderer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_glyph_renderer: self-checking bench of the glyph renderer
// Loads glyphs into the font store, moves the cursor and prints characters
// under several register settings, with random gaps and stalls on both
// channels. A scoreboard class tracks cursor, registers and font contents and
// checks every glyph row draw in order against its own prediction.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_renderer;
    import tgr_pkg::*;

    localparam int FONT_HEIGHT = 16;
    localparam int GLYPH_COUNT = 256;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_REPORTS = 10;

    // Mode that the block ignores
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [MODE_W-1:0]          mode;
        logic [CODE_W-1:0]          code;
        logic [GROW_W-1:0]          grow;
        logic [BITS_W-1:0]          bits;
        logic signed [SETPOS_W-1:0] set_row;
        logic signed [SETPOS_W-1:0] set_col;
    } console_item_t;

    typedef struct {
        logic [OFF_W-1:0]  pixel_offset;
        logic [BITS_W-1:0] row_mask;
        logic              last;
    } glyph_draw_t;

    // ------------------------------------------------------------------------
    // Scoreboard: cursor and font tracking, expected draw queue
    // ------------------------------------------------------------------------
    class glyph_scoreboard;
        int unsigned enable;
        int unsigned landscape;
        int unsigned max_cols;
        int unsigned max_rows;
        int unsigned panel_rows;
        int unsigned line_pixels;
        int unsigned cur_row;
        int unsigned cur_col;
        logic [BITS_W-1:0] font [GLYPH_COUNT*FONT_HEIGHT];
        glyph_draw_t expected_draws[$];
        int errors;

        function new();
            enable = 0;
            landscape = 0;
            max_cols = 80;
            max_rows = 30;
            panel_rows = 480;
            line_pixels = 640;
            cur_row = 0;
            cur_col = 0;
            errors = 0;
        endfunction

        function int outstanding();
            return expected_draws.size();
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_ENABLE:      enable = value[0];
                REG_ORIENTATION: landscape = value[0];
                REG_MAX_COLS:    max_cols = value[7:0];
                REG_MAX_ROWS:    max_rows = value[7:0];
                REG_PANEL_ROWS:  panel_rows = value;
                REG_LINE_LEN:    line_pixels = value;
                default: ;
            endcase
        endfunction

        // Negative or zero requests go to 0, large ones to the limit
        function int unsigned clamp_pos(logic [SETPOS_W-1:0] raw, int unsigned hi);
            if (raw[SETPOS_W-1] || raw == '0)
                return 0;
            return (raw > hi) ? hi : raw;
        endfunction

        // Newline: column 0, next row, wrap to the top without scrolling
        function void new_line();
            int unsigned r;
            r = cur_row + 1;
            cur_col = 0;
            if (r >= max_rows)
                r = 0;
            cur_row = r & 8'hFF;
        endfunction

        function void note_item(console_item_t it);
            int unsigned x;
            int unsigned y;
            int unsigned c;
            logic [31:0] off;
            glyph_draw_t d;
            case (it.mode)
                MODE_FONT: font[it.code*FONT_HEIGHT + it.grow] = it.bits;
                MODE_SET:
                begin
                    cur_row = clamp_pos(it.set_row, max_rows);
                    cur_col = clamp_pos(it.set_col, max_cols);
                end
                MODE_CHAR:
                begin
                    if (enable != 0)
                    begin
                        case (it.code)
                            CH_CR: cur_col = 0;
                            CH_LF: new_line();
                            CH_TAB:
                            begin
                                c = (cur_col + 8) & ~32'd7;
                                if (c >= max_cols)
                                    new_line();
                                else
                                    cur_col = c & 8'hFF;
                            end
                            CH_BS:
                            begin
                                if (cur_col == 0)
                                begin
                                    cur_col = (max_cols - 1) & 8'hFF;
                                    if (cur_row != 0)
                                        cur_row = cur_row - 1;
                                end
                                else
                                    cur_col = cur_col - 1;
                            end
                            default:
                            begin
                                // One draw per glyph row, then advance the cursor
                                x = cur_col * FONT_WIDTH;
                                for (int r = 0; r < FONT_HEIGHT; r++)
                                begin
                                    y = cur_row * FONT_HEIGHT + r;
                                    if (landscape != 0)
                                        off = x + y * line_pixels;
                                    else
                                        off = y + (panel_rows - 1 - x) * line_pixels;
                                    d.pixel_offset = off[OFF_W-1:0];
                                    d.row_mask = (it.code < GLYPH_COUNT) ?
                                                 font[it.code*FONT_HEIGHT + r] : '0;
                                    d.last = (r == FONT_HEIGHT - 1);
                                    expected_draws.push_back(d);
                                end
                                c = cur_col + 1;
                                if (c >= max_cols)
                                    new_line();
                                else
                                    cur_col = c & 8'hFF;
                            end
                        endcase
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_draw(glyph_draw_t got);
            glyph_draw_t want;
            if (expected_draws.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected draw: off=%06h mask=%02h last=%0d",
                             got.pixel_offset, got.row_mask, got.last);
                return;
            end
            want = expected_draws.pop_front();
            if (got.pixel_offset !== want.pixel_offset || got.row_mask !== want.row_mask ||
                got.last !== want.last)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"draw mismatch: expected off=%06h mask=%02h last=%0d,",
                              " got off=%06h mask=%02h last=%0d"},
                             want.pixel_offset, want.row_mask, want.last,
                             got.pixel_offset, got.row_mask, got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tgr_char_if chars_if ();
    tgr_draw_if draws_if ();

    glyph_scoreboard sb;

    // Stimulus knowledge: which font rows hold data, which glyphs can print
    bit [FONT_HEIGHT-1:0] rows_written [GLYPH_COUNT];
    bit                   listed [GLYPH_COUNT];
    logic [CODE_W-1:0]    printable_codes[$];

    bit hold_req;
    bit steady;

    text_console_glyph_renderer #(
        .FONT_HEIGHT (FONT_HEIGHT),
        .GLYPH_COUNT (GLYPH_COUNT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_if),
        .draws     (draws_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // Random idle length: mostly short, a few long
    function automatic int idle_length();
        if ($urandom_range(99) < 80)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Draw receiver: random stalls, plus one long hold-off on request
    initial
    begin : draw_sink
        int stall_left;
        int holdoff_left;
        stall_left = 0;
        holdoff_left = 0;
        draws_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                hold_req = 1'b0;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                draws_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                draws_if.ready <= 1'b0;
            end
            else
            begin
                draws_if.ready <= 1'b1;
                if (!steady && $urandom_range(99) < 20)
                    stall_left = idle_length();
            end
        end
    end

    // Transaction monitor: note accepted items, check accepted draws
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (chars_if.valid && chars_if.ready)
                sb.note_item(console_item_t'{chars_if.mode, chars_if.char_code,
                                             chars_if.glyph_row, chars_if.font_bits,
                                             chars_if.set_row, chars_if.set_col});
            if (draws_if.valid && draws_if.ready)
                sb.check_draw(glyph_draw_t'{draws_if.pixel_offset, draws_if.row_mask,
                                            draws_if.last});
        end
    end

    function automatic console_item_t make_item(logic [MODE_W-1:0] mode,
                                                logic [CODE_W-1:0] code,
                                                logic [GROW_W-1:0] grow,
                                                logic [BITS_W-1:0] bits,
                                                logic [SETPOS_W-1:0] srow,
                                                logic [SETPOS_W-1:0] scol);
        console_item_t it;
        it.mode = mode;
        it.code = code;
        it.grow = grow;
        it.bits = bits;
        it.set_row = srow;
        it.set_col = scol;
        return it;
    endfunction

    // Offer one item and wait until the block takes it
    task automatic offer(input console_item_t it);
        int gap;
        gap = (steady || $urandom_range(99) < 65) ? 0 : idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            chars_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        chars_if.mode      <= it.mode;
        chars_if.char_code <= it.code;
        chars_if.glyph_row <= it.grow;
        chars_if.font_bits <= it.bits;
        chars_if.set_row   <= it.set_row;
        chars_if.set_col   <= it.set_col;
        chars_if.valid     <= 1'b1;
        do
            @(posedge clk);
        while (!chars_if.ready);
    endtask

    task automatic send_char(input logic [CODE_W-1:0] code);
        offer(make_item(MODE_CHAR, code, GROW_W'($urandom), BITS_W'($urandom),
                        SETPOS_W'($urandom), SETPOS_W'($urandom)));
    endtask

    task automatic set_pos(input int row, input int col);
        offer(make_item(MODE_SET, CODE_W'($urandom), GROW_W'($urandom), BITS_W'($urandom),
                        SETPOS_W'(row), SETPOS_W'(col)));
    endtask

    task automatic send_unused();
        offer(make_item(MODE_UNUSED, CODE_W'($urandom), GROW_W'($urandom),
                        BITS_W'($urandom), SETPOS_W'($urandom), SETPOS_W'($urandom)));
    endtask

    task automatic font_write(input int code, input int grow, input int bits);
        logic [CODE_W-1:0] c8;
        logic [GROW_W-1:0] g4;
        c8 = CODE_W'(code);
        g4 = GROW_W'(grow);
        offer(make_item(MODE_FONT, c8, g4, BITS_W'(bits),
                        SETPOS_W'($urandom), SETPOS_W'($urandom)));
        rows_written[c8][g4] = 1'b1;
        if (&rows_written[c8] && !listed[c8] &&
            !(c8 inside {CH_BS, CH_TAB, CH_LF, CH_CR}))
        begin
            listed[c8] = 1'b1;
            printable_codes.push_back(c8);
        end
    endtask

    task automatic load_glyph(input int code);
        for (int r = 0; r < FONT_HEIGHT; r++)
            font_write(code, r, $urandom);
    endtask

    function automatic logic [CODE_W-1:0] pick_printable();
        return printable_codes[$urandom_range(printable_codes.size() - 1)];
    endfunction

    function automatic logic [CODE_W-1:0] pick_control();
        case ($urandom_range(3))
            0: return CH_BS;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Random code that is a control character or a fully loaded glyph
    function automatic logic [CODE_W-1:0] pick_any();
        logic [CODE_W-1:0] code;
        code = CODE_W'($urandom);
        if (&rows_written[code] || (code inside {CH_BS, CH_TAB, CH_LF, CH_CR}))
            return code;
        return pick_printable();
    endfunction

    // Drop valid, wait for every expected draw, then let the block settle
    task automatic quiesce(input int settle);
        @(negedge clk);
        chars_if.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        sb.apply_reg(idx, CFG_DATA_W'(value));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input int enable, input int landscape, input int cols,
                                input int rows, input int panel, input int line_len);
        quiesce(FONT_HEIGHT + 8);
        write_reg(REG_ENABLE, enable);
        write_reg(REG_ORIENTATION, landscape);
        write_reg(REG_MAX_COLS, cols);
        write_reg(REG_MAX_ROWS, rows);
        write_reg(REG_PANEL_ROWS, panel);
        write_reg(REG_LINE_LEN, line_len);
    endtask

    task automatic apply_random_config();
        apply_config(1, $urandom_range(1), $urandom_range(255, 1), $urandom_range(255, 1),
                     $urandom_range(4095, 1), $urandom_range(4095, 1));
    endtask

    // Mixed traffic: mostly printing on loaded glyphs, with cursor moves,
    // font updates, ignored items and the odd pause until drained
    task automatic run_random(input int count);
        int sel;
        int n;
        n = 0;
        while (n < count)
        begin
            sel = $urandom_range(99);
            n++;
            if (sel < 47)
                send_char(pick_printable());
            else if (sel < 60)
                send_char(pick_control());
            else if (sel < 66)
                set_pos(int'($urandom_range(sb.max_rows + 2)) - 1,
                        int'($urandom_range(sb.max_cols + 2)) - 1);
            else if (sel < 70)
                set_pos($urandom, $urandom);
            else if (sel < 74)
            begin
                load_glyph($urandom);
                n += FONT_HEIGHT - 1;
            end
            else if (sel < 90)
                font_write($urandom, $urandom, $urandom);
            else if (sel < 94)
                send_unused();
            else if (sel < 96)
            begin
                quiesce(0);
                n--;
            end
            else
                send_char(pick_any());
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        chars_if.valid = 1'b0;
        chars_if.mode = MODE_CHAR;
        chars_if.char_code = '0;
        chars_if.glyph_row = '0;
        chars_if.font_bits = '0;
        chars_if.set_row = '0;
        chars_if.set_col = '0;
        hold_req = 1'b0;
        steady = 1'b0;
        sb = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Console off after reset: load a few glyphs, characters are ignored
        load_glyph(8'h41);
        load_glyph(8'h00);
        load_glyph(8'hFF);
        font_write(8'h41, 0, 8'h00);
        font_write(8'h41, FONT_HEIGHT - 1, 8'hFF);
        send_char(8'h41);
        send_unused();
        set_pos(3, 5);

        // Directed cursor cases in landscape
        apply_config(1, 1, 80, 30, 480, 640);
        set_pos(-512, -512);
        send_char(8'h41);
        send_char(8'hFF);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(8'h00);
        send_char(CH_TAB);
        send_char(CH_BS);
        // backspace at column 0 on the top row
        set_pos(0, 0);
        send_char(CH_BS);
        send_char(8'h41);
        // backspace at column 0 steps up a row
        set_pos(2, 0);
        send_char(CH_BS);
        // cursor parked at the column and row limits
        set_pos(511, 511);
        send_char(8'hFF);
        // tab past the last column, newline wrap at the bottom
        set_pos(29, 78);
        send_char(CH_TAB);
        set_pos(29, 3);
        send_char(CH_LF);
        send_char(8'h41);
        send_unused();

        // Portrait at reset geometry
        apply_config(1, 0, 80, 30, 480, 640);
        run_random(40);

        // Largest geometry
        apply_config(1, 0, 255, 255, 4095, 4095);
        run_random(35);

        // Smallest geometry
        apply_config(1, 1, 1, 1, 1, 1);
        run_random(30);

        // Zero columns and rows: every advance wraps to the origin
        apply_config(1, 0, 0, 0, 1, 4095);
        send_char(CH_BS);
        send_char(8'h41);
        send_char(CH_TAB);
        send_char(CH_LF);
        run_random(16);

        // Receiver holds off while characters keep coming
        apply_random_config();
        hold_req = 1'b1;
        steady = 1'b1;
        repeat (6) send_char(pick_printable());
        steady = 1'b0;
        run_random(30);
        quiesce(0);
        run_random(10);

        // No idling on either side
        apply_random_config();
        steady = 1'b1;
        run_random(35);
        steady = 1'b0;

        // Console off: only font writes and cursor sets take effect
        apply_config(0, 1, 40, 20, 300, 800);
        run_random(20);

        apply_random_config();
        run_random(25);

        quiesce(FONT_HEIGHT + 8);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
